// File: sv/acl_pkg.sv
// Shared types, constants and helper functions of the IPv4 prefix access list.
package acl_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;

  // Longest legal prefix; longer lengths saturate to this value.
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

  // Command codes of an input transaction.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Width of one stored rule: prefix length above the masked network.
  localparam int unsigned RULE_W = ADDR_W + LEN_W;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } item_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

  // Network mask for a prefix length of 0 to 32.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// File: sv/acl_ram.sv
// Generic single-port RAM with registered read data.
module acl_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// File: sv/acl_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
module acl_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [acl_pkg::ADDR_W-1:0]          in_address,
  input  logic [acl_pkg::LEN_W-1:0]           in_prefix_length,
  output logic                                q_valid,
  output acl_pkg::item_t                      q_item,
  input  logic                                q_pop
);

  acl_pkg::item_t           item;
  logic [acl_pkg::LEN_W-1:0] len_sat;
  logic                     push;

  acl_pkg::item_t entry_r [2];
  logic [1:0]     fill_r;
  logic           wr_ptr_r;
  logic           rd_ptr_r;

  // Lengths above 32 saturate; an add stores its network already masked.
  always_comb begin
    len_sat   = (in_prefix_length > acl_pkg::LEN_MAX) ? acl_pkg::LEN_MAX : in_prefix_length;
    item.cmd  = in_command;
    item.len  = len_sat;
    item.addr = (in_command == acl_pkg::CMD_ADD) ?
                (in_address & acl_pkg::prefix_mask(len_sat)) : in_address;
  end

  assign in_stall = (fill_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (q_pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item;
    end
  end

endmodule

// File: sv/acl_back.sv
// Back end: appends rules to the table and scans the table for address checks.
module acl_back #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  acl_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_matched,
  output logic           out_status,
  output logic [CW-1:0]  rule_count
);

  acl_pkg::bk_state_t state_r, state_nxt;

  logic [CW-1:0]              count_r;
  logic [CW-1:0]              rd_idx_r;
  logic                       rd_vld_r;
  logic                       hit_r;
  logic [acl_pkg::ADDR_W-1:0] addr_r;
  logic                       out_valid_r;
  logic                       out_matched_r;
  logic                       out_status_r;

  logic                       out_free;
  logic                       table_full;
  logic                       issue_done;
  logic                       ram_we;
  logic                       rd_en;
  logic                       out_load;
  logic                       load_matched;
  logic                       load_status;
  logic                       hit_now;
  logic [AW-1:0]              ram_addr;
  logic [acl_pkg::RULE_W-1:0] ram_wdata;
  logic [acl_pkg::RULE_W-1:0] ram_rdata;

  assign out_free   = !out_valid_r || !out_stall;
  assign table_full = (count_r == CW'(DEPTH));
  assign issue_done = (rd_idx_r == count_r);

  assign ram_addr  = ram_we ? count_r[AW-1:0] : rd_idx_r[AW-1:0];
  assign ram_wdata = {q_item.len, q_item.addr};

  assign hit_now = ((addr_r ^ ram_rdata[acl_pkg::ADDR_W-1:0]) &
                    acl_pkg::prefix_mask(ram_rdata[acl_pkg::RULE_W-1:acl_pkg::ADDR_W]))
                   == '0;

  acl_ram #(
    .WIDTH (acl_pkg::RULE_W),
    .DEPTH (DEPTH)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acl_pkg::BK_IDLE: begin
        if (q_valid && out_free && (q_item.cmd == acl_pkg::CMD_CHECK) && (count_r != '0)) begin
          state_nxt = acl_pkg::BK_SCAN;
        end
      end
      acl_pkg::BK_SCAN: begin
        if (issue_done && !rd_vld_r) begin
          state_nxt = acl_pkg::BK_DONE;
        end
      end
      acl_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = acl_pkg::BK_IDLE;
        end
      end
      default: state_nxt = acl_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    load_matched = 1'b0;
    load_status  = 1'b0;
    unique case (state_r)
      acl_pkg::BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.cmd == acl_pkg::CMD_ADD) begin
            out_load    = 1'b1;
            load_status = table_full;
            ram_we      = !table_full;
          end else if (count_r == '0) begin
            out_load = 1'b1;
          end
        end
      end
      acl_pkg::BK_SCAN: begin
        rd_en = !issue_done;
      end
      acl_pkg::BK_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          load_matched = hit_r;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acl_pkg::BK_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (ram_we) begin
        count_r <= count_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_idx_r <= '0;
      hit_r    <= 1'b0;
      addr_r   <= q_item.addr;
    end else begin
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (rd_vld_r) begin
        hit_r <= hit_r | hit_now;
      end
    end
    if (out_load) begin
      out_matched_r <= load_matched;
      out_status_r  <= load_status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;
  assign out_status  = out_status_r;
  assign rule_count  = count_r;

endmodule

// File: sv/ipv4_prefix_acl_match.sv
// Top level of the IPv4 prefix access list: front end, queue and table back end.
//
// This block keeps a list of up to RULE_DEPTH IPv4 prefix rules and answers
// whether an address falls inside any of them. An add transaction (command 0)
// masks the address to its prefix length, saturating lengths above 32 to 32,
// and appends the rule; when the table already holds RULE_DEPTH rules the rule
// is dropped and status 1 is returned. A check transaction (command 1) reports
// matched 1 if the address lies in any stored rule; a rule of length 0 matches
// every address. Every input transaction yields exactly one result transaction,
// in order. The front end classifies transactions into a two-entry queue, so
// input is taken while the back end is busy or a result waits on out_stall.
// In the back end, an add and a check of an empty table are finished in the
// idle state that takes them, while a check of a table with rules runs a scan,
// because the rule table sits in a single-port RAM that the back end reads one
// rule per cycle: the idle state takes the transaction, the scan state issues
// the reads, folds in the last read data and closes the scan, and the done
// state loads the result register. A result held by out_stall adds its stall
// cycles. The table needs no clearing after reset, since only entries below the
// rule count are ever read.
module ipv4_prefix_acl_match #(
  parameter int unsigned RULE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [acl_pkg::ADDR_W-1:0] in_address,
  input  logic [acl_pkg::LEN_W-1:0]  in_prefix_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_matched,
  output logic                       out_status
);

  localparam int unsigned CW = $clog2(RULE_DEPTH + 1);

  logic           q_valid;
  logic           q_pop;
  acl_pkg::item_t q_item;
  logic [CW-1:0]  rule_count;

  // Front end: classification and the decoupling queue.
  acl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_address       (in_address),
    .in_prefix_length (in_prefix_length),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  // Back end: rule table, scan sequencer and the output register.
  acl_back #(
    .DEPTH (RULE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_matched (out_matched),
    .out_status  (out_status),
    .rule_count  (rule_count)
  );

  // The back end must only take an item that the queue actually holds.
  a_pop_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  // A result is either a check answer or an add status, never both.
  a_result_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_matched && out_status))
    else $error("result reports both a match and a full table");

  // The table never holds more rules than it has room for.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    rule_count <= CW'(RULE_DEPTH))
    else $error("rule count exceeds table depth");

  // Rules are only ever appended, one per cycle at most.
  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    (rule_count != $past(rule_count)) |-> (rule_count == $past(rule_count) + CW'(1)))
    else $error("rule count changed by other than one");

endmodule
